// ===== hdl/tbrg_pkg.sv =====
// Shared types, codes and constants for the token bucket replay guard.
// Used by tbrg_refill and token_bucket_replay_guard; depends on nothing.
`default_nettype none

package tbrg_pkg;

	// Geometry of the slot table and the id window.
	localparam int unsigned CONNECTIONS = 16;
	localparam int unsigned WINDOW      = 64;
	localparam int unsigned SLOT_W      = $clog2(CONNECTIONS);
	localparam int unsigned WPOS_W      = $clog2(WINDOW);
	localparam int unsigned FILL_W      = WPOS_W + 1;
	localparam int unsigned MEM_AW      = SLOT_W + WPOS_W;

	// Field widths.
	localparam int unsigned LEVEL_W = 32;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned ID_W    = 32;
	localparam int unsigned RATE_W  = 24;
	localparam int unsigned BURST_W = 16;
	localparam int unsigned RWIN_W  = 7;
	localparam int unsigned PROD_W  = 16 + RATE_W;

	// One whole token in Q16.16.
	localparam logic [LEVEL_W-1:0] ONE_TOKEN  = 32'h0001_0000;
	localparam logic [RATE_W-1:0]  MIN_RATE   = 24'h01_0000;
	localparam logic [RWIN_W-1:0]  MIN_WINDOW = 7'd8;
	localparam logic [RWIN_W-1:0]  MAX_WINDOW = RWIN_W'(WINDOW);

	// Register reset values.
	localparam logic [BURST_W-1:0] BURST_RESET = 16'd8;
	localparam logic [RATE_W-1:0]  RATE_RESET  = 24'h01_0000;
	localparam logic [RWIN_W-1:0]  RWIN_RESET  = 7'd16;

	// Configuration register indexes.
	localparam logic [1:0] CFG_BURST  = 2'd0;
	localparam logic [1:0] CFG_RATE   = 2'd1;
	localparam logic [1:0] CFG_WINDOW = 2'd2;

	// Commands.
	localparam logic CMD_REQUEST = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_DUP     = 2'd2;
	localparam logic [1:0] ST_LIMITED = 2'd3;

	// Result of the refill unit.
	typedef struct packed {
		logic [LEVEL_W-1:0] level;  // refilled and clamped level
		logic               whole;  // at least one whole token present
	} refill_res_t;

	// Bucket ceiling in Q16.16; a zero burst acts as one token.
	function automatic logic [LEVEL_W-1:0] bucket_cap(input logic [BURST_W-1:0] burst);
		logic [BURST_W-1:0] b;
		b = (burst == '0) ? BURST_W'(1) : burst;
		return {b, 16'h0000};
	endfunction

	// Refill rate with a floor of one token per tick.
	function automatic logic [RATE_W-1:0] eff_rate(input logic [RATE_W-1:0] rate);
		return (rate < MIN_RATE) ? MIN_RATE : rate;
	endfunction

	// Window size clamped to the supported range.
	function automatic logic [FILL_W-1:0] eff_window(input logic [RWIN_W-1:0] w);
		logic [RWIN_W-1:0] c;
		c = w;
		if (c < MIN_WINDOW) c = MIN_WINDOW;
		if (c > MAX_WINDOW) c = MAX_WINDOW;
		return FILL_W'(c);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/tbrg_refill.sv =====
// Refill unit of the token bucket replay guard: elapsed time, multiply, clamp.
// Two register stages; depends on tbrg_pkg.
`default_nettype none

module tbrg_refill (
	input  wire logic                           clk,
	input  wire logic [tbrg_pkg::LEVEL_W-1:0]   level,
	input  wire logic [tbrg_pkg::TIME_W-1:0]    last,
	input  wire logic [tbrg_pkg::TIME_W-1:0]    now,
	input  wire logic [tbrg_pkg::RATE_W-1:0]    rate,
	input  wire logic [tbrg_pkg::LEVEL_W-1:0]   cap,
	output tbrg_pkg::refill_res_t               res
);

	logic [15:0]                  elapsed_s1;
	logic                         sat_s1;
	logic [tbrg_pkg::PROD_W-1:0]  prod_s2;
	logic                         sat_s2;
	logic [tbrg_pkg::TIME_W-1:0]  elapsed;
	logic [tbrg_pkg::PROD_W:0]    sum;
	logic [tbrg_pkg::LEVEL_W-1:0] clamped;

	// Time going back counts as no elapsed time.
	assign elapsed = (now >= last) ? (now - last) : '0;

	// At one token per tick or more, 65536 ticks overfill any bucket.
	always_ff @(posedge clk) begin
		elapsed_s1 <= elapsed[15:0];
		sat_s1     <= (elapsed[31:16] != '0);
	end

	always_ff @(posedge clk) begin
		prod_s2 <= tbrg_pkg::PROD_W'(elapsed_s1) * tbrg_pkg::PROD_W'(rate);
		sat_s2  <= sat_s1;
	end

	always_comb begin
		sum = (tbrg_pkg::PROD_W+1)'(level) + (tbrg_pkg::PROD_W+1)'(prod_s2);
		if (sat_s2 || (sum > (tbrg_pkg::PROD_W+1)'(cap))) begin
			clamped = cap;
		end else begin
			clamped = sum[tbrg_pkg::LEVEL_W-1:0];
		end
		res.level = clamped;
		res.whole = (clamped >= tbrg_pkg::ONE_TOKEN);
	end

endmodule

`default_nettype wire

// ===== hdl/token_bucket_replay_guard.sv =====
// Top level of the token bucket replay guard: command sequencer, slot table,
// id window memory. Depends on tbrg_pkg and tbrg_refill.
`default_nettype none

// Usage
// A command word is taken at a clock edge where start is high and busy is low.
// Each command word produces exactly one result word, shown on status and
// accepted for the single cycle in which done is high; the receiver cannot
// stall, so results are never held back or repeated.
// A release or a request with a non-positive id answers in the cycle after it
// is taken. A valid request first checks the slot's id window, one stored id per
// cycle through the single read port of the window memory, then refills the
// bucket through the multiply and clamp unit. With n ids remembered in the
// slot (up to 64 for a full window), a passing request passes through the
// lookup state, a scan of those n ids, then the multiply and decide states; a
// duplicate answers once the match is seen. busy stays high until the cycle the
// result is shown, so the next command can be taken in the same cycle as done.
// Configuration writes through cfg_we, cfg_index and cfg_data take effect at
// once and are expected only while the block is idle; unknown indexes are
// ignored. Reset clears all slots and loads the default registers; the window
// memory needs no clearing since per-slot fill counts guard its reads.

module token_bucket_replay_guard (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// command channel
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                command,
	input  wire logic [3:0]                          connection_id,
	input  wire logic signed [tbrg_pkg::ID_W-1:0]    request_id,
	input  wire logic [tbrg_pkg::TIME_W-1:0]         now_ticks,
	// result channel
	output logic                                     done,
	output logic [1:0]                               status,
	output logic                                     accepted,
	// configuration port
	input  wire logic                                cfg_we,
	input  wire logic [1:0]                          cfg_index,
	input  wire logic [tbrg_pkg::RATE_W-1:0]         cfg_data
);

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_LOOKUP = 5'b00010,
		S_SCAN   = 5'b00100,
		S_MUL    = 5'b01000,
		S_DECIDE = 5'b10000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [tbrg_pkg::BURST_W-1:0] burst_q;
	logic [tbrg_pkg::RATE_W-1:0]  rate_q;
	logic [tbrg_pkg::RWIN_W-1:0]  rwin_q;

	// Per-slot state, kept in flip-flops so reset clears it at once.
	logic [tbrg_pkg::CONNECTIONS-1:0] started_q;
	logic [tbrg_pkg::LEVEL_W-1:0]     level_q [tbrg_pkg::CONNECTIONS];
	logic [tbrg_pkg::TIME_W-1:0]      last_q  [tbrg_pkg::CONNECTIONS];
	logic [tbrg_pkg::WPOS_W-1:0]      head_q  [tbrg_pkg::CONNECTIONS];
	logic [tbrg_pkg::FILL_W-1:0]      fill_q  [tbrg_pkg::CONNECTIONS];

	// Latched command word and working copy of the slot.
	logic [tbrg_pkg::SLOT_W-1:0]  slot_q;
	logic [tbrg_pkg::ID_W-1:0]    id_q;
	logic [tbrg_pkg::TIME_W-1:0]  now_q;
	logic [tbrg_pkg::LEVEL_W-1:0] wlevel_q;
	logic [tbrg_pkg::TIME_W-1:0]  wlast_q;
	logic [tbrg_pkg::WPOS_W-1:0]  whead_q;
	logic [tbrg_pkg::FILL_W-1:0]  wfill_q;

	// Scan counter and read pipeline flag.
	logic [tbrg_pkg::FILL_W-1:0]  k_q;
	logic                         pend_q;

	// Result registers.
	logic       done_q;
	logic [1:0] status_q;
	logic       acc_q;

	// Window memory: one row of WINDOW ids per slot.
	logic [tbrg_pkg::ID_W-1:0]    win_mem [2**tbrg_pkg::MEM_AW];
	logic [tbrg_pkg::ID_W-1:0]    rdata_q;
	logic [tbrg_pkg::MEM_AW-1:0]  raddr;
	logic [tbrg_pkg::MEM_AW-1:0]  waddr;
	logic                         mem_we;

	// Derived values.
	logic [tbrg_pkg::SLOT_W-1:0]  in_slot;
	logic                         id_bad;
	logic [tbrg_pkg::LEVEL_W-1:0] cap;
	logic [tbrg_pkg::FILL_W-1:0]  lim;
	logic [tbrg_pkg::FILL_W-1:0]  drop;
	logic                         issue;
	logic                         hit;
	tbrg_pkg::refill_res_t        refill;

	assign in_slot = connection_id[tbrg_pkg::SLOT_W-1:0];
	// A valid id is positive: sign bit clear and not zero.
	assign id_bad  = (request_id == '0) || request_id[tbrg_pkg::ID_W-1];
	assign cap     = tbrg_pkg::bucket_cap(burst_q);
	assign lim     = tbrg_pkg::eff_window(rwin_q);

	// When the window is full, drop enough of the oldest ids to make room.
	assign drop = (wfill_q >= lim) ? (wfill_q - lim + tbrg_pkg::FILL_W'(1)) : '0;

	assign issue  = (k_q < wfill_q);
	assign hit    = pend_q && (rdata_q == id_q);
	assign raddr  = {slot_q, whead_q + k_q[tbrg_pkg::WPOS_W-1:0]};
	// The new id lands right after the newest one; dropping does not move that spot.
	assign waddr  = {slot_q, whead_q + wfill_q[tbrg_pkg::WPOS_W-1:0]};
	assign mem_we = (state_q == S_DECIDE) && refill.whole;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			win_mem[waddr] <= id_q;
		end
		rdata_q <= win_mem[raddr];
	end

	tbrg_refill u_refill (
		.clk   (clk),
		.level (wlevel_q),
		.last  (wlast_q),
		.now   (now_q),
		.rate  (tbrg_pkg::eff_rate(rate_q)),
		.cap   (cap),
		.res   (refill)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_q <= tbrg_pkg::BURST_RESET;
			rate_q  <= tbrg_pkg::RATE_RESET;
			rwin_q  <= tbrg_pkg::RWIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tbrg_pkg::CFG_BURST:  burst_q <= cfg_data[tbrg_pkg::BURST_W-1:0];
				tbrg_pkg::CFG_RATE:   rate_q  <= cfg_data;
				tbrg_pkg::CFG_WINDOW: rwin_q  <= cfg_data[tbrg_pkg::RWIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Payload registers of the working copy; no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					slot_q <= in_slot;
					id_q   <= request_id;
					now_q  <= now_ticks;
				end
			end
			S_LOOKUP: begin
				// A slot on its first use starts full at the current time.
				wlevel_q <= started_q[slot_q] ? level_q[slot_q] : cap;
				wlast_q  <= started_q[slot_q] ? last_q[slot_q]  : now_q;
				whead_q  <= head_q[slot_q];
				wfill_q  <= fill_q[slot_q];
			end
			default: ;
		endcase
	end

	// Sequencer, slot table and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			started_q <= '0;
			for (int i = 0; i < tbrg_pkg::CONNECTIONS; i++) begin
				level_q[i] <= '0;
				last_q[i]  <= '0;
				head_q[i]  <= '0;
				fill_q[i]  <= '0;
			end
			k_q      <= '0;
			pend_q   <= 1'b0;
			done_q   <= 1'b0;
			status_q <= tbrg_pkg::ST_OK;
			acc_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (command == tbrg_pkg::CMD_RELEASE) begin
							started_q[in_slot] <= 1'b0;
							level_q[in_slot]   <= '0;
							last_q[in_slot]    <= '0;
							head_q[in_slot]    <= '0;
							fill_q[in_slot]    <= '0;
							done_q   <= 1'b1;
							status_q <= tbrg_pkg::ST_OK;
							acc_q    <= 1'b0;
						end else if (id_bad) begin
							done_q   <= 1'b1;
							status_q <= tbrg_pkg::ST_INVALID;
							acc_q    <= 1'b0;
						end else begin
							state_q <= S_LOOKUP;
						end
					end
				end
				S_LOOKUP: begin
					// The first-use fill stays even if the request turns out a duplicate.
					if (!started_q[slot_q]) begin
						started_q[slot_q] <= 1'b1;
						level_q[slot_q]   <= cap;
						last_q[slot_q]    <= now_q;
					end
					k_q     <= '0;
					pend_q  <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					// One read issued per cycle; its data is compared the cycle after.
					pend_q <= issue;
					if (issue) begin
						k_q <= k_q + tbrg_pkg::FILL_W'(1);
					end
					if (hit) begin
						done_q   <= 1'b1;
						status_q <= tbrg_pkg::ST_DUP;
						acc_q    <= 1'b0;
						state_q  <= S_IDLE;
					end else if (!issue) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					last_q[slot_q] <= now_q;
					done_q         <= 1'b1;
					if (refill.whole) begin
						level_q[slot_q] <= refill.level - tbrg_pkg::ONE_TOKEN;
						head_q[slot_q]  <= whead_q + drop[tbrg_pkg::WPOS_W-1:0];
						fill_q[slot_q]  <= wfill_q - drop + tbrg_pkg::FILL_W'(1);
						status_q        <= tbrg_pkg::ST_OK;
						acc_q           <= 1'b1;
					end else begin
						level_q[slot_q] <= refill.level;
						status_q        <= tbrg_pkg::ST_LIMITED;
						acc_q           <= 1'b0;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign status   = status_q;
	assign accepted = acc_q;

endmodule

`default_nettype wire
